### rtl/core/rau_pkg.sv
// Package for the rational accumulator unit: word range constants, op and
// status codes, controller states and controller/datapath bundles.
// No dependencies.
package rau_pkg;

    localparam int WORD_BITS = 32;
    // fields are 32 bits wide, so the usable word range stops at 32
    localparam int EFF_BITS  = (WORD_BITS > 32) ? 32 : WORD_BITS;

    localparam logic [63:0] NUM_NEG_MAX = 64'd1 << (EFF_BITS - 1);
    localparam logic [63:0] NUM_POS_MAX = NUM_NEG_MAX - 64'd1;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_ADD  = 2'd1;
    localparam logic [1:0] OP_MUL  = 2'd2;
    localparam logic [1:0] OP_NOP  = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZDEN = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_GCD,
        S_DIVN,
        S_DIVD,
        S_OPCHK,
        S_MUL_P1,
        S_MUL_P2,
        S_ADD,
        S_MUL_N,
        S_MUL_D,
        S_RESCHK,
        S_RGCD,
        S_COMMIT,
        S_FINISH
    } state_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD_IN,
        CMD_ZERO,
        CMD_GCD_START,
        CMD_DIVN_START,
        CMD_TAKE_N,
        CMD_TAKE_D,
        CMD_SAVE_OP,
        CMD_MUL_P1,
        CMD_MUL_P2,
        CMD_ADD,
        CMD_MUL_N,
        CMD_MUL_D,
        CMD_CHECK,
        CMD_COMMIT,
        CMD_OUT_LOAD
    } dp_cmd_t;

    typedef struct packed {
        dp_cmd_t cmd;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       zden;
        logic       x_zero;
        logic       fits;
        logic       gcd_done;
        logic       div_done;
    } dp_status_t;

    // sign-magnitude numerator and denominator inside the word range
    function automatic logic fits_range(input logic neg, input logic [63:0] n,
                                        input logic [63:0] d);
        logic n_ok;
        n_ok = neg ? (n <= NUM_NEG_MAX) : (n <= NUM_POS_MAX);
        return n_ok && (d != 64'd0) && (d <= NUM_POS_MAX);
    endfunction

endpackage

### rtl/core/rau_if.sv
// Valid/ready channel interfaces for the rational accumulator unit.
// Operand channel and result channel. No dependencies.
interface rau_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic signed [31:0] operand_num;
    logic signed [31:0] operand_den;

    modport source (output valid, output op, output operand_num, output operand_den,
                    input ready);
    modport sink   (input valid, input op, input operand_num, input operand_den,
                    output ready);
endinterface

interface rau_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_num;
    logic [30:0]        result_den;
    logic [1:0]         status;

    modport source (output valid, output result_num, output result_den, output status,
                    input ready);
    modport sink   (input valid, input result_num, input result_den, input status,
                    output ready);
endinterface

### rtl/core/rau_gcd.sv
// Binary (Stein) GCD of two nonzero 32-bit magnitudes, one step per cycle.
// Depends on rau_pkg only by convention; no imports needed.
module rau_gcd (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] a_in,
    input  logic [31:0] b_in,
    output logic        done,
    output logic [31:0] g
);
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [31:0] a_reg, b_reg;
    logic [4:0]  k_reg;
    logic        equal;

    assign equal = (a_reg == b_reg);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg && equal)
        begin
            busy_next = 1'b0;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a_in;
            b_reg <= b_in;
            k_reg <= '0;
        end
        else if (busy_reg && !equal)
        begin
            if (!a_reg[0] && !b_reg[0])
            begin
                a_reg <= a_reg >> 1;
                b_reg <= b_reg >> 1;
                k_reg <= k_reg + 5'd1;
            end
            else if (!a_reg[0])
                a_reg <= a_reg >> 1;
            else if (!b_reg[0])
                b_reg <= b_reg >> 1;
            else if (a_reg > b_reg)
                a_reg <= a_reg - b_reg;
            else
                b_reg <= b_reg - a_reg;
        end
    end

    assign done = done_reg;
    assign g    = a_reg << k_reg;
endmodule

### rtl/core/rau_div.sv
// Restoring 32-bit unsigned divider, one quotient bit per cycle.
// Used for exact division by the GCD. No dependencies.
module rau_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg;
    logic [31:0] rem_reg, quo_reg, dsr_reg;
    logic [32:0] shifted;
    logic        take;

    assign shifted = {rem_reg, quo_reg[31]};
    assign take    = (shifted >= {1'b0, dsr_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg && (cnt_reg == 5'd31))
        begin
            busy_next = 1'b0;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
            cnt_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? 32'(shifted - {1'b0, dsr_reg}) : shifted[31:0];
            quo_reg <= {quo_reg[30:0], take};
            cnt_reg <= cnt_reg + 5'd1;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

### rtl/core/rau_datapath.sv
// Datapath of the rational accumulator unit: accumulator, working fraction,
// shared multiplier, GCD unit and divider. Depends on rau_pkg, rau_gcd, rau_div.
module rau_datapath
    import rau_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  ctrl_cmd_t          ctrl,
    output dp_status_t         stat,
    input  logic [1:0]         op,
    input  logic signed [31:0] operand_num,
    input  logic signed [31:0] operand_den,
    output logic signed [31:0] result_num,
    output logic [30:0]        result_den,
    output logic [1:0]         status
);
    logic [31:0] acc_num_reg, acc_num_next;
    logic [30:0] acc_den_reg, acc_den_next;
    logic [1:0]  op_reg, status_reg;
    logic        zden_reg;
    logic [63:0] xn_reg, xd_reg, p1_reg, p2_reg;
    logic        xs_reg;
    logic [31:0] on_reg, od_reg;
    logic        on_neg_reg;
    logic signed [31:0] out_num_reg;
    logic [30:0] out_den_reg;
    logic [1:0]  out_status_reg;

    logic [31:0] num_bits, den_bits, num_mag, den_mag, an_mag;
    logic        an_neg, fits, s1, s2;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic        gcd_done, div_done, div_start;
    logic [31:0] gcd_g, quotient, dividend;

    assign num_bits = operand_num;
    assign den_bits = operand_den;
    assign num_mag  = num_bits[31] ? (~num_bits + 32'd1) : num_bits;
    assign den_mag  = den_bits[31] ? (~den_bits + 32'd1) : den_bits;
    assign an_neg   = acc_num_reg[31];
    assign an_mag   = an_neg ? (~acc_num_reg + 32'd1) : acc_num_reg;
    assign fits     = fits_range(xs_reg, xn_reg, xd_reg);
    assign s1       = on_neg_reg && (p1_reg != 64'd0);
    assign s2       = an_neg && (p2_reg != 64'd0);

    // one shared 32x32 multiplier, product always lands in a register
    always_comb
    begin
        case (ctrl.cmd)
            CMD_MUL_P1:
            begin
                mul_a = on_reg;
                mul_b = {1'b0, acc_den_reg};
            end
            CMD_MUL_P2:
            begin
                mul_a = an_mag;
                mul_b = od_reg;
            end
            CMD_MUL_N:
            begin
                mul_a = an_mag;
                mul_b = on_reg;
            end
            default:
            begin
                mul_a = od_reg;
                mul_b = {1'b0, acc_den_reg};
            end
        endcase
    end
    assign mul_p = 64'(mul_a) * 64'(mul_b);

    assign div_start = (ctrl.cmd == CMD_DIVN_START) || (ctrl.cmd == CMD_TAKE_N);
    assign dividend  = (ctrl.cmd == CMD_TAKE_N) ? xd_reg[31:0] : xn_reg[31:0];

    rau_gcd u_gcd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctrl.cmd == CMD_GCD_START),
        .a_in  (xn_reg[31:0]),
        .b_in  (xd_reg[31:0]),
        .done  (gcd_done),
        .g     (gcd_g)
    );

    rau_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (gcd_g),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        acc_num_next = acc_num_reg;
        acc_den_next = acc_den_reg;
        if (ctrl.cmd == CMD_COMMIT)
        begin
            acc_num_next = xs_reg ? (~xn_reg[31:0] + 32'd1) : xn_reg[31:0];
            acc_den_next = xd_reg[30:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_num_reg <= '0;
            acc_den_reg <= 31'd1;
        end
        else
        begin
            acc_num_reg <= acc_num_next;
            acc_den_reg <= acc_den_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (ctrl.cmd)
            CMD_LOAD_IN:
            begin
                op_reg   <= op;
                zden_reg <= (den_bits == 32'd0);
                status_reg <= ((op != OP_NOP) && (den_bits == 32'd0)) ? ST_ZDEN : ST_OK;
                if (den_bits == 32'd0)
                begin
                    xn_reg <= 64'd1;
                    xd_reg <= 64'd1;
                    xs_reg <= 1'b0;
                end
                else
                begin
                    xn_reg <= {32'd0, num_mag};
                    xd_reg <= {32'd0, den_mag};
                    xs_reg <= (num_bits != 32'd0) && (num_bits[31] ^ den_bits[31]);
                end
            end
            CMD_ZERO:
            begin
                xs_reg <= 1'b0;
                xd_reg <= 64'd1;
            end
            CMD_TAKE_N: xn_reg <= {32'd0, quotient};
            CMD_TAKE_D: xd_reg <= {32'd0, quotient};
            CMD_SAVE_OP:
            begin
                on_reg     <= xn_reg[31:0];
                od_reg     <= xd_reg[31:0];
                on_neg_reg <= xs_reg;
                if (!fits)
                    status_reg <= ST_OVF;
            end
            CMD_MUL_P1: p1_reg <= mul_p;
            CMD_MUL_P2: p2_reg <= mul_p;
            CMD_MUL_N:
            begin
                xn_reg <= mul_p;
                xs_reg <= an_neg ^ on_neg_reg;
            end
            CMD_MUL_D: xd_reg <= mul_p;
            CMD_ADD:
            begin
                if (s1 == s2)
                begin
                    xn_reg <= p1_reg + p2_reg;
                    xs_reg <= s1;
                end
                else if (p1_reg >= p2_reg)
                begin
                    xn_reg <= p1_reg - p2_reg;
                    xs_reg <= s1;
                end
                else
                begin
                    xn_reg <= p2_reg - p1_reg;
                    xs_reg <= s2;
                end
            end
            CMD_CHECK:
            begin
                if (!fits)
                    status_reg <= ST_OVF;
                else if (xn_reg == 64'd0)
                begin
                    xs_reg <= 1'b0;
                    xd_reg <= 64'd1;
                end
            end
            CMD_OUT_LOAD:
            begin
                out_num_reg    <= acc_num_reg;
                out_den_reg    <= acc_den_reg;
                out_status_reg <= status_reg;
            end
            default: ;
        endcase
    end

    assign stat.op       = op_reg;
    assign stat.zden     = zden_reg;
    assign stat.x_zero   = (xn_reg == 64'd0);
    assign stat.fits     = fits;
    assign stat.gcd_done = gcd_done;
    assign stat.div_done = div_done;

    assign result_num = out_num_reg;
    assign result_den = out_den_reg;
    assign status     = out_status_reg;
endmodule

### rtl/core/rau_ctrl.sv
// Controller of the rational accumulator unit: sequences normalization,
// reduction, products and output handshake. Depends on rau_pkg.
module rau_ctrl
    import rau_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output ctrl_cmd_t  ctrl,
    input  dp_status_t stat
);
    state_t state_reg, state_next;
    logic   phase_reg, phase_next;      // 0 operand reduction, 1 result reduction
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ctrl.cmd       = CMD_NONE;
        in_ready       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.cmd   = CMD_LOAD_IN;
                    phase_next = 1'b0;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.op == OP_NOP)
                    state_next = S_FINISH;
                else if (stat.zden)
                    state_next = S_OPCHK;
                else if (stat.x_zero)
                begin
                    ctrl.cmd   = CMD_ZERO;
                    state_next = S_OPCHK;
                end
                else
                begin
                    ctrl.cmd   = CMD_GCD_START;
                    state_next = S_GCD;
                end
            end
            S_GCD:
            begin
                if (stat.gcd_done)
                begin
                    ctrl.cmd   = CMD_DIVN_START;
                    state_next = S_DIVN;
                end
            end
            S_DIVN:
            begin
                if (stat.div_done)
                begin
                    ctrl.cmd   = CMD_TAKE_N;
                    state_next = S_DIVD;
                end
            end
            S_DIVD:
            begin
                if (stat.div_done)
                begin
                    ctrl.cmd   = CMD_TAKE_D;
                    state_next = phase_reg ? S_COMMIT : S_OPCHK;
                end
            end
            S_OPCHK:
            begin
                ctrl.cmd = CMD_SAVE_OP;
                if (!stat.fits)
                    state_next = S_FINISH;
                else if (stat.op == OP_LOAD)
                    state_next = S_COMMIT;
                else if (stat.op == OP_ADD)
                    state_next = S_MUL_P1;
                else
                    state_next = S_MUL_N;
            end
            S_MUL_P1:
            begin
                ctrl.cmd   = CMD_MUL_P1;
                state_next = S_MUL_P2;
            end
            S_MUL_P2:
            begin
                ctrl.cmd   = CMD_MUL_P2;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                ctrl.cmd   = CMD_ADD;
                state_next = S_MUL_D;
            end
            S_MUL_N:
            begin
                ctrl.cmd   = CMD_MUL_N;
                state_next = S_MUL_D;
            end
            S_MUL_D:
            begin
                ctrl.cmd   = CMD_MUL_D;
                state_next = S_RESCHK;
            end
            S_RESCHK:
            begin
                ctrl.cmd = CMD_CHECK;
                if (!stat.fits)
                    state_next = S_FINISH;
                else if (stat.x_zero)
                    state_next = S_COMMIT;
                else
                begin
                    phase_next = 1'b1;
                    state_next = S_RGCD;
                end
            end
            S_RGCD:
            begin
                ctrl.cmd   = CMD_GCD_START;
                state_next = S_GCD;
            end
            S_COMMIT:
            begin
                ctrl.cmd   = CMD_COMMIT;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    ctrl.cmd       = CMD_OUT_LOAD;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign out_valid = out_valid_reg;
endmodule

### rtl/core/rational_accumulator_unit.sv
// Rational accumulator unit: top level, joins controller and datapath.
// Depends on rau_pkg, rau_if, rau_ctrl, rau_datapath.
//
// Keeps a signed fraction acc_num/acc_den in lowest terms (reset 0/1). Each
// operand item loads, adds or multiplies by a fraction; op 3 leaves the
// accumulator alone. Each item yields one result item with the accumulator
// after the step and a status: ok, zero operand denominator replaced by 1/1,
// or overflow (state kept). One item is in work at a time; the result sits in
// an output register, so the next operand item is accepted while it waits.
// A reduction is one pass of the binary GCD, made of shift or subtract
// steps, plus two 32-step divisions, one for the numerator and one for the
// denominator. An add passes three times through the shared 32x32
// multiplier. A zero operand numerator or denominator skips the operand
// reduction; a zero or overflowing result skips the result reduction.
module rational_accumulator_unit
    import rau_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    rau_in_if.sink    operand,
    rau_out_if.source result
);
    ctrl_cmd_t  ctrl;
    dp_status_t stat;

    rau_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (operand.valid),
        .in_ready  (operand.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .ctrl      (ctrl),
        .stat      (stat)
    );

    rau_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .stat        (stat),
        .op          (operand.op),
        .operand_num (operand.operand_num),
        .operand_den (operand.operand_den),
        .result_num  (result.result_num),
        .result_den  (result.result_den),
        .status      (result.status)
    );
endmodule

### rtl/core/rau_checker.sv
// Port-level checks for the rational accumulator unit, bound to the top.
// Depends on rau_pkg.
module rau_checker
    import rau_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] result_num,
    input logic [30:0]        result_den,
    input logic [1:0]         status
);
    a_den_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (result_den != 31'd0))
        else $error("result denominator is zero");

    a_zero_canon: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (result_num == 32'sd0)) |-> (result_den == 31'd1))
        else $error("zero result not shown as 0/1");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("operand taken while an item is in work");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(result_num) && $stable(result_den) && $stable(status)))
        else $error("stalled result changed");
endmodule

bind rational_accumulator_unit rau_checker u_rau_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (operand.valid),
    .in_ready   (operand.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .result_num (result.result_num),
    .result_den (result.result_den),
    .status     (result.status)
);
